// ===== rtl/rmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbd_pkg: shared types and constants of the retro machine bus decoder
// Command and result words, queue entry, address map and region decode.
// ----------------------------------------------------------------------------
package rmbd_pkg;

	localparam int RAM_BYTES = 65536;
	localparam int RAM_AW    = $clog2(RAM_BYTES);

	localparam logic [23:0] RAM_TOP = 24'(RAM_BYTES);
	localparam logic [23:0] VID_LO  = 24'hFF8200;
	localparam logic [23:0] VID_HI  = 24'hFF827F;
	localparam logic [23:0] SND_LO  = 24'hFF8800;
	localparam logic [23:0] SND_HI  = 24'hFF8803;
	localparam logic [23:0] TMR_LO  = 24'hFFFA00;
	localparam logic [23:0] TMR_HI  = 24'hFFFA3F;
	localparam logic [23:0] SER_LO  = 24'hFFFC00;
	localparam logic [23:0] SER_HI  = 24'hFFFC07;
	localparam logic [23:0] ROM_LO  = 24'hFC0000;
	localparam logic [23:0] ROM_HI  = 24'hFEFFFF;
	localparam logic [3:0]  SEL_MASK = 4'hF;

	localparam logic [6:0] OFF_BASE_HI = 7'h01;
	localparam logic [6:0] OFF_BASE_MI = 7'h03;
	localparam logic [6:0] OFF_BASE_LO = 7'h0D;
	localparam logic [6:0] OFF_SYNC    = 7'h0A;
	localparam logic [6:0] OFF_RES     = 7'h60;
	localparam logic [7:0] SYNC_RESET  = 8'h02;

	localparam logic [1:0] SND_OFF_SEL  = 2'd0;
	localparam logic [1:0] SND_OFF_DATA = 2'd2;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;
	localparam logic [1:0] SIZE_LONG = 2'd2;

	typedef enum logic [2:0] {
		REG_NONE, REG_RAM, REG_ROM, REG_VID, REG_SND, REG_TMR, REG_SER
	} region_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  access_size;
		logic [23:0] address;
		logic [31:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bus_error;
		logic [23:0] screen_base;
		logic [1:0]  resolution;
	} res_t;

	// queue entry: classified access
	typedef struct packed {
		logic        is_write;
		logic        err;
		logic [1:0]  last;       // byte count minus one
		logic [23:0] address;
		logic [31:0] wdata;      // top byte first
		logic [31:0] err_data;   // read data when err
	} job_t;

	function automatic region_t region_of(logic [23:0] a);
		region_t r;
		r = REG_NONE;
		if (a < RAM_TOP) r = REG_RAM;
		else if (a >= ROM_LO && a <= ROM_HI) r = REG_ROM;
		else if (a >= VID_LO && a <= VID_HI) r = REG_VID;
		else if (a >= SND_LO && a <= SND_HI) r = REG_SND;
		else if (a >= TMR_LO && a <= TMR_HI) r = REG_TMR;
		else if (a >= SER_LO && a <= SER_HI) r = REG_SER;
		return r;
	endfunction

endpackage

// ===== rtl/retro_machine_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// retro_machine_bus_decoder: 24-bit bus decoder of a small retro machine
// Front classifies and queues accesses, back runs them byte by byte.
// ----------------------------------------------------------------------------
// channel   | handshake           | word
// command   | start & !busy       | cmd (cmd_t)
// result    | result_valid strobe | result (res_t)
// config    | cfg_valid & ready   | cfg_data (powered_on)
//
// An access that is rejected skips the byte engine; a write or read runs one
// byte per cycle through the single-port RAM and register files, after a
// stay in the queue. The queue holds two words; busy is high when it is
// full. After reset a clearing pass sets the video and timer register files
// while the queue still takes up to two words; the other device registers
// clear at reset and RAM is not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module retro_machine_bus_decoder import rmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic result_valid,
	output res_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic job_valid, job_pop;
	job_t job;

	assign cfg_ready = 1'b1;

	rmbd_front u_front (
		.clk, .arst_n, .start, .busy, .cmd,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_data,
		.job_valid, .job, .job_pop
	);

	rmbd_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop, .result_valid, .result
	);

endmodule

// ===== rtl/rmbd_front.sv =====
// ----------------------------------------------------------------------------
// rmbd_front: command intake and classification
// Checks power, size, alignment and byte regions, queues classified words.
// ----------------------------------------------------------------------------
module rmbd_front import rmbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	input  logic        cfg_data,
	output logic        job_valid,
	output job_t        job,
	input  logic        job_pop
);

	logic       powered_q;
	job_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	job_t       cls;
	logic [1:0] last;
	logic       bad_any, nw_any;
	region_t    rg;

	// power register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) powered_q <= 1'b0;
		else if (cfg_valid) powered_q <= cfg_data;
	end

	// classify one command word
	always_comb begin
		last = (cmd.access_size == SIZE_BYTE) ? 2'd0 :
		       (cmd.access_size == SIZE_WORD) ? 2'd1 : 2'd3;
		bad_any = 1'b0;
		nw_any  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rg = region_of(cmd.address + 24'(i));
			if (2'(i) <= last) begin
				if (rg == REG_NONE) bad_any = 1'b1;
				if (rg == REG_NONE || rg == REG_ROM) nw_any = 1'b1;
			end
		end
		cls.is_write = cmd.kind;
		cls.last     = last;
		cls.address  = cmd.address;
		cls.wdata    = cmd.write_data << (6'd8 * (6'd3 - {4'd0, last}));
		cls.err_data = (last == 2'd0) ? 32'h0000_00FF :
		               (last == 2'd1) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
		cls.err = !powered_q || (cmd.access_size == 2'd3)
		       || (cmd.access_size != SIZE_BYTE && cmd.address[0])
		       || (cmd.kind ? nw_any : bad_any);
	end

	assign busy      = (count_q == 2'd2);
	assign push      = start && !busy;
	assign job_valid = (count_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (job_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, job_pop};
		end
	end

endmodule

// ===== rtl/rmbd_back.sv =====
// ----------------------------------------------------------------------------
// rmbd_back: byte-serial access engine
// Runs queued words one byte per cycle over RAM and device register files.
// ----------------------------------------------------------------------------
module rmbd_back import rmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic result_valid,
	output res_t result
);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_RDL, S_WR, S_DONE} state_t;

	state_t      state_q;
	job_t        cur_q;
	logic [23:0] addr_q;
	logic [1:0]  cnt_q;
	logic        pend_q;
	logic [31:0] rdata_q;
	logic [31:0] wd_q;
	logic        res_valid_q;
	res_t        res_q;

	logic [7:0]  ram_q [RAM_BYTES];
	logic [7:0]  vid_q [128];
	logic [7:0]  tmr_q [64];
	logic [7:0]  ser_q [8];
	logic [7:0]  snd_q [16];
	logic [3:0]  sel_q;
	logic [23:0] base_q;
	logic [1:0]  resol_q;

	logic [6:0]  clr_q;
	logic        clr_busy_q;

	logic [7:0]  ram_rd_q, oth_rd_q;
	logic        rd_is_ram_q;
	logic [7:0]  rd_byte;
	region_t     rg;
	logic        wr_en;
	logic [7:0]  wbyte;
	logic [23:0] off;

	assign rg      = region_of(addr_q);
	assign off     = addr_q - VID_LO;
	assign wr_en   = (state_q == S_WR);
	assign wbyte   = wd_q[31:24];
	assign rd_byte = rd_is_ram_q ? ram_rd_q : oth_rd_q;
	assign job_pop = (state_q == S_IDLE) && job_valid && !clr_busy_q;

	// clearing pass over the video and timer files after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 7'd0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 7'd1;
			if (clr_q == 7'd127) clr_busy_q <= 1'b0;
		end
	end

	// RAM, registered read
	always_ff @(posedge clk) begin
		if (wr_en && rg == REG_RAM) ram_q[addr_q[RAM_AW-1:0]] <= wbyte;
		ram_rd_q <= ram_q[addr_q[RAM_AW-1:0]];
	end

	// video register file; sync byte comes out of the clear at its reset value
	always_ff @(posedge clk) begin
		if (clr_busy_q) vid_q[clr_q] <= (clr_q == OFF_SYNC) ? SYNC_RESET : 8'h00;
		else if (wr_en && rg == REG_VID) vid_q[off[6:0]] <= wbyte;
	end

	// timer register file
	always_ff @(posedge clk) begin
		if (clr_busy_q) tmr_q[clr_q[5:0]] <= 8'h00;
		else if (wr_en && rg == REG_TMR) tmr_q[addr_q[5:0]] <= wbyte;
	end

	// device register read, registered
	always_ff @(posedge clk) begin
		rd_is_ram_q <= (rg == REG_RAM);
		unique case (rg)
			REG_VID: oth_rd_q <= vid_q[addr_q[6:0]];
			REG_SND: oth_rd_q <= (addr_q[1:0] == SND_OFF_SEL) ? snd_q[sel_q & SEL_MASK]
			                                                   : 8'hFF;
			REG_TMR: oth_rd_q <= tmr_q[addr_q[5:0]];
			REG_SER: oth_rd_q <= ser_q[addr_q[2:0]];
			default: oth_rd_q <= 8'hFF;
		endcase
	end

	// small device registers and shifter side effects
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) ser_q[i] <= 8'h00;
			for (int i = 0; i < 16; i++) snd_q[i] <= 8'h00;
			sel_q   <= 4'd0;
			base_q  <= 24'd0;
			resol_q <= 2'd0;
		end else if (wr_en) begin
			unique case (rg)
				REG_VID: begin
					if (off[6:0] == OFF_BASE_HI) base_q[23:16] <= wbyte;
					if (off[6:0] == OFF_BASE_MI) base_q[15:8] <= wbyte;
					if (off[6:0] == OFF_BASE_LO) base_q[7:0] <= wbyte;
					if (off[6:0] == OFF_RES) resol_q <= wbyte[1:0];
				end
				REG_SND: begin
					if (addr_q[1:0] == SND_OFF_SEL) sel_q <= wbyte[3:0] & SEL_MASK;
					else if (addr_q[1:0] == SND_OFF_DATA) snd_q[sel_q] <= wbyte;
				end
				REG_SER: ser_q[addr_q[2:0]] <= wbyte;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					cnt_q  <= 2'd0;
					if (job_pop) begin
						cur_q   <= job;
						addr_q  <= job.address;
						wd_q    <= job.wdata;
						rdata_q <= (job.err && !job.is_write) ? job.err_data : 32'd0;
						if (job.err) state_q <= S_DONE;
						else if (job.is_write) state_q <= S_WR;
						else state_q <= S_RD;
					end
				end
				S_RD: begin
					if (pend_q) rdata_q <= {rdata_q[23:0], rd_byte};
					pend_q <= 1'b1;
					addr_q <= addr_q + 24'd1;
					cnt_q  <= cnt_q + 2'd1;
					if (cnt_q == cur_q.last) state_q <= S_RDL;
				end
				S_RDL: begin
					rdata_q <= {rdata_q[23:0], rd_byte};
					state_q <= S_DONE;
				end
				S_WR: begin
					wd_q   <= {wd_q[23:0], 8'h00};
					addr_q <= addr_q + 24'd1;
					cnt_q  <= cnt_q + 2'd1;
					if (cnt_q == cur_q.last) state_q <= S_DONE;
				end
				S_DONE: begin
					res_valid_q       <= 1'b1;
					res_q.read_data   <= rdata_q;
					res_q.bus_error   <= cur_q.err;
					res_q.screen_base <= base_q;
					res_q.resolution  <= resol_q;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a result is a single-cycle strobe
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |=> !res_valid_q)
		else $error("result strobe longer than one cycle");

	// rejected words never reach the byte engine
	a_no_err_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR || state_q == S_RD) |-> !cur_q.err)
		else $error("errored word executing");

	// a result follows in the cycle after the done state
	a_done_res: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> res_valid_q)
		else $error("done without result");

	// nothing leaves the queue while the register files are cleared
	a_clr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !job_pop)
		else $error("word taken during clearing pass");

endmodule

// ===== bench/tb_retro_machine_bus_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_retro_machine_bus_decoder: self-checking bench of the bus decoder
// Drives byte, word and long accesses over the whole address map, predicts
// each result word with a software copy of the device state and compares.
// ----------------------------------------------------------------------------

// Expected-result store and decoder state copy
class bus_scoreboard;
	rmbd_pkg::res_t pending[$];
	logic [7:0]  ram_mem[int];
	logic [7:0]  vid_mem[128];
	logic [7:0]  snd_mem[16];
	logic [7:0]  tmr_mem[64];
	logic [7:0]  ser_mem[8];
	logic [3:0]  snd_sel;
	logic [23:0] scr_base;
	logic [1:0]  res_code;
	bit          power;
	int          errors;
	int          checked;

	function new();
		foreach (vid_mem[i]) vid_mem[i] = 8'h00;
		vid_mem[rmbd_pkg::OFF_SYNC] = rmbd_pkg::SYNC_RESET;
		foreach (snd_mem[i]) snd_mem[i] = 8'h00;
		foreach (tmr_mem[i]) tmr_mem[i] = 8'h00;
		foreach (ser_mem[i]) ser_mem[i] = 8'h00;
		snd_sel  = '0;
		scr_base = '0;
		res_code = '0;
		power    = 0;
		errors   = 0;
		checked  = 0;
	endfunction

	// 0 none, 1 ram, 2 rom, 3 video, 4 sound, 5 timer, 6 serial
	function int zone(logic [23:0] a);
		if (a < 24'(rmbd_pkg::RAM_BYTES)) return 1;
		if (a >= 24'hFC0000 && a <= 24'hFEFFFF) return 2;
		if (a >= 24'hFF8200 && a <= 24'hFF827F) return 3;
		if (a >= 24'hFF8800 && a <= 24'hFF8803) return 4;
		if (a >= 24'hFFFA00 && a <= 24'hFFFA3F) return 5;
		if (a >= 24'hFFFC00 && a <= 24'hFFFC07) return 6;
		return 0;
	endfunction

	function logic [7:0] peek(logic [23:0] a);
		case (zone(a))
			1: return ram_mem.exists(int'(a)) ? ram_mem[int'(a)] : 8'h00;
			3: return vid_mem[a[6:0]];
			4: return (a[1:0] == 2'd0) ? snd_mem[snd_sel] : 8'hFF;
			5: return tmr_mem[a[5:0]];
			6: return ser_mem[a[2:0]];
			default: return 8'hFF;
		endcase
	endfunction

	function void poke(logic [23:0] a, logic [7:0] b);
		logic [6:0] o;
		case (zone(a))
			1: ram_mem[int'(a)] = b;
			3: begin
				o = a[6:0];
				vid_mem[o] = b;
				if (o == 7'h01 || o == 7'h03 || o == 7'h0D)
					scr_base = {vid_mem[7'h01], vid_mem[7'h03], vid_mem[7'h0D]};
				else if (o == 7'h60)
					res_code = b[1:0];
			end
			4: begin
				if (a[1:0] == 2'd0) snd_sel = b[3:0];
				else if (a[1:0] == 2'd2) snd_mem[snd_sel] = b;
			end
			5: tmr_mem[a[5:0]] = b;
			6: ser_mem[a[2:0]] = b;
			default: ;
		endcase
	endfunction

	// Note one accepted command word and queue its expected result
	function void note_access(rmbd_pkg::cmd_t c);
		rmbd_pkg::res_t r;
		int n;
		bit fail;
		logic [23:0] a;
		n = (c.access_size == 2'd0) ? 1 : (c.access_size == 2'd1) ? 2 :
			(c.access_size == 2'd2) ? 4 : 0;
		fail = !power || n == 0 || (n > 1 && c.address[0]);
		r.read_data = '0;
		for (int i = 0; i < n && !fail; i++) begin
			a = c.address + 24'(i);
			if (zone(a) == 0 || (c.kind && zone(a) == 2)) fail = 1;
			else if (!c.kind) r.read_data = {r.read_data[23:0], peek(a)};
		end
		if (!c.kind && fail)
			r.read_data = (n == 1) ? 32'hFF : (n == 2) ? 32'hFFFF : 32'hFFFF_FFFF;
		if (c.kind && !fail)
			for (int i = 0; i < n; i++)
				poke(c.address + 24'(i), c.write_data[8*(n-1-i) +: 8]);
		r.bus_error   = fail;
		r.screen_base = scr_base;
		r.resolution  = res_code;
		pending.push_back(r);
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %h expected %h", what, got, want);
	endfunction

	// Compare one result word with the oldest expectation
	function void check_result(rmbd_pkg::res_t got);
		rmbd_pkg::res_t want;
		if (pending.size() == 0) begin
			report("unexpected result", 32'(got.bus_error), 0);
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
		if (got.bus_error !== want.bus_error)
			report("bus_error", 32'(got.bus_error), 32'(want.bus_error));
		if (got.screen_base !== want.screen_base)
			report("screen_base", 32'(got.screen_base), 32'(want.screen_base));
		if (got.resolution !== want.resolution)
			report("resolution", 32'(got.resolution), 32'(want.resolution));
	endfunction
endclass

module tb_retro_machine_bus_decoder;
	import rmbd_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	cmd_t cmd = '0;
	logic result_valid;
	res_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;

	bus_scoreboard sb = new();
	int idle_pct = 0;
	int n_reads = 0, n_writes = 0, n_errs = 0;

	retro_machine_bus_decoder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (result.bus_error) n_errs++;
			sb.check_result(result);
		end
	end

	// Issue one command word and wait for it to be taken
	task automatic issue(cmd_t c);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) @(negedge clk);
		cmd   = c;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note_access(c);
		if (c.kind) n_writes++; else n_reads++;
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 10000) begin
			@(negedge clk);
			guard++;
		end
		repeat (12) @(negedge clk);
	endtask

	task automatic set_power(bit v);
		drain();
		cfg_data  = v;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.power = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic cmd_t mk(bit k, logic [1:0] s, logic [23:0] a, logic [31:0] d);
		cmd_t c;
		c.kind = k; c.access_size = s; c.address = a; c.write_data = d;
		return c;
	endfunction

	// Random access; RAM reads only hit bytes already written
	task automatic random_access();
		logic [1:0]  s;
		logic [23:0] a;
		bit k;
		int r, n;
		s = ($urandom_range(30, 0) == 0) ? 2'd3 : 2'($urandom_range(2, 0));
		n = (s == 0) ? 1 : (s == 1) ? 2 : 4;
		k = $urandom_range(1, 0);
		r = $urandom_range(9, 0);
		case (r)
			0, 1, 2: a = 24'($urandom_range(255, 0));
			3: a = 24'hFF8200 + 24'($urandom_range(127, 0));
			4: a = 24'hFF8200 + 24'($urandom_range(7, 0) < 4 ?
				$urandom_range(31, 0) + 64 : $urandom_range(15, 0));
			5: a = 24'hFF8800 + 24'($urandom_range(3, 0));
			6: a = 24'hFFFA00 + 24'($urandom_range(63, 0));
			7: a = 24'hFFFC00 + 24'($urandom_range(7, 0));
			8: a = 24'($urandom_range(24'h03FFFF, 0)) + 24'hFC0000;
			default: a = 24'($urandom());
		endcase
		if ($urandom_range(7, 0) != 0 && s != 3) a[0] = (n == 1) ? a[0] : 1'b0;
		// a RAM read must land on bytes already written
		if (!k && sb.power)
			for (int i = 0; i < n; i++)
				if (sb.zone(a + 24'(i)) == 1 && !sb.ram_mem.exists(int'(a + 24'(i))))
					k = 1;
		issue(mk(k, s, a, $urandom()));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Power off: everything errors
		issue(mk(0, SIZE_BYTE, 24'hFF820A, 0));
		issue(mk(1, SIZE_LONG, 24'h000000, 32'hDEADBEEF));
		set_power(1);

		// Directed: extremes, each region, special cases
		issue(mk(1, SIZE_LONG, 24'h000000, 32'hFFFFFFFF));
		issue(mk(0, SIZE_LONG, 24'h000000, 0));
		issue(mk(1, SIZE_WORD, 24'h00FFFE, 32'h0000A55A));
		issue(mk(0, SIZE_WORD, 24'h00FFFE, 0));
		issue(mk(1, SIZE_LONG, 24'h00FFFE, 32'h12345678));   // crosses into unmapped
		issue(mk(0, SIZE_BYTE, 24'h010000, 0));
		issue(mk(0, SIZE_LONG, 24'hFC0000, 0));              // ROM reads ones
		issue(mk(1, SIZE_BYTE, 24'hFEFFFF, 32'h11));         // ROM write
		issue(mk(1, SIZE_WORD, 24'h000001, 32'h1234));       // unaligned
		issue(mk(0, SIZE_LONG, 24'h000003, 0));
		issue(mk(0, 2'd3, 24'h000000, 0));                   // bad size
		issue(mk(1, 2'd3, 24'h000000, 32'hFFFFFFFF));
		issue(mk(1, SIZE_BYTE, 24'hFF8201, 32'hFF));         // screen base
		issue(mk(1, SIZE_LONG, 24'hFF820C, 32'hAA55CC33));
		issue(mk(1, SIZE_BYTE, 24'hFF8260, 32'hFF));         // resolution
		issue(mk(1, SIZE_LONG, 24'hFF8240, 32'hBEEFCAFE));   // palette
		issue(mk(0, SIZE_LONG, 24'hFF8208, 0));              // sync byte
		issue(mk(1, SIZE_WORD, 24'hFF8800, 32'h0F07));       // sound select
		issue(mk(1, SIZE_BYTE, 24'hFF8802, 32'h99));
		issue(mk(0, SIZE_LONG, 24'hFF8800, 0));
		issue(mk(1, SIZE_LONG, 24'hFFFA3C, 32'h01020304));
		issue(mk(0, SIZE_LONG, 24'hFFFC04, 0));
		issue(mk(0, SIZE_WORD, 24'hFFFFFE, 0));              // unmapped top
		issue(mk(1, SIZE_BYTE, 24'h7FFFFF, 32'h5A));

		// Random phases with different sender idling
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 63 : 18;
			repeat (270) random_access();
			if (ph == 2) begin
				set_power(0);
				repeat (20) random_access();
				set_power(1);
			end else if (ph == 4) begin
				drain();  // sender holds until all results are in
			end
		end
		idle_pct = 0;
		set_power(0);

		drain();
		$display("covered %0d reads, %0d writes, %0d rejected; %0d results checked",
			n_reads, n_writes, n_errs, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
